[design/wur_pkg.sv]
// Package for the wavetable upload receiver: transfer item types, reply codes,
// header magic words, register indexes and the sample key hash.
// No dependencies.
package wur_pkg;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic REG_TABLE_LIMIT = 1'b0;
  localparam logic REG_IDLE_TICKS  = 1'b1;
  localparam logic [8:0]  TABLE_LIMIT_RESET = 9'd256;
  localparam logic [15:0] IDLE_TICKS_RESET  = 16'd100;

  // default table cap
  localparam int unsigned MAX_TABLES_DEF = 256;

  // reply codes
  localparam logic [1:0] REPLY_ACK = 2'd0;
  localparam logic [1:0] REPLY_ERR = 2'd1;
  localparam logic [1:0] REPLY_FIN = 2'd2;

  // input item kinds
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // header bytes: four magic words then the length word, last byte position
  localparam logic [3:0] HDR_LAST_POS = 4'd9;

  typedef logic [15:0] magic_arr_t [4];
  localparam magic_arr_t MAGIC_WORDS = '{16'd29960, 16'd62903, 16'd35185, 16'd26662};

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        sample_write;
    logic [7:0]  write_table;
    logic [15:0] write_index;
    logic [15:0] write_value;
    logic        reply_valid;
    logic [1:0]  reply_code;
    logic        commit;
    logic [8:0]  tables_loaded;
    logic [15:0] table_length;
  } out_item_t;

  // 16-bit integer hash of a sample value, the expected key
  function automatic logic [15:0] value_hash(input logic [15:0] v);
    logic [15:0] k;
    k = (16'hFFFF ^ v) + (v << 15);
    k = k ^ (k >> 12);
    k = k + (k << 2);
    k = k ^ (k >> 4);
    // times 2057
    k = k + (k << 3) + (k << 11);
    return k;
  endfunction

endpackage

[design/wur_out_buf.sv]
// Two-entry result buffer: an output register plus a skid register, so the
// upstream side keeps transferring while a result waits. Uses wur_pkg.
module wur_out_buf (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  wur_pkg::out_item_t push_data,
  output logic               full,
  output logic               result_valid,
  input  logic               result_stall,
  output wur_pkg::out_item_t result
);
  import wur_pkg::*;

  logic      main_valid;
  out_item_t main_data;
  logic      skid_valid;
  out_item_t skid_data;
  logic      pop;

  assign pop          = main_valid && !result_stall;
  assign full         = skid_valid;
  assign result_valid = main_valid;
  assign result       = main_data;

  // control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (!main_valid) begin
      main_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (!main_valid) begin
      main_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

[design/wavetable_upload_receiver.sv]
// Wavetable upload receiver top level: header hunt, sample key check, table
// write generation, idle timeout and APB configuration. Uses wur_pkg, wur_out_buf.
//
//   channel  direction  handshake                 payload
//   item     in         item_valid / item_stall   in_item_t  (mode, rx_byte)
//   result   out        result_valid/result_stall out_item_t (one per item)
//   config   in         psel/penable/pwrite/pready table_limit, idle_ticks
//
// One item per cycle while item_stall is low: the whole step (header compare, key hash,
// counters) is one pass of logic from the state registers into the result buffer.
// A transferred item's result is registered in the output or the skid register.
// rst is synchronous and clears all state and loads the register defaults.
// item_stall rises only when both result buffer entries are held by a stall.
module wavetable_upload_receiver #(
  parameter int unsigned MAX_TABLES = wur_pkg::MAX_TABLES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  wur_pkg::in_item_t        item,
  output logic                     result_valid,
  input  logic                     result_stall,
  output wur_pkg::out_item_t       result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [wur_pkg::ADDR_W-1:0] paddr,
  input  logic [wur_pkg::DATA_W-1:0] pwdata,
  output logic [wur_pkg::DATA_W-1:0] prdata,
  output logic                     pready
);
  import wur_pkg::*;

  localparam logic [8:0] LimCap = (MAX_TABLES < 511) ? 9'(MAX_TABLES) : 9'd511;

  // configuration registers
  logic [8:0]  table_limit;
  logic [15:0] idle_ticks;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_limit <= TABLE_LIMIT_RESET;
      idle_ticks  <= IDLE_TICKS_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_TABLE_LIMIT) begin
        table_limit <= pwdata[8:0];
      end else begin
        idle_ticks <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_IDLE_TICKS) begin
      prdata = {16'd0, idle_ticks};
    end else begin
      prdata = {23'd0, table_limit};
    end
  end

  // upload state
  logic        in_sample_phase, in_sample_phase_next;
  logic [3:0]  byte_position, byte_position_next;
  logic [7:0]  hi_byte, hi_byte_next;
  logic [15:0] key_word, key_word_next;
  logic        magic_mismatch, magic_mismatch_next;
  logic [15:0] samples_per_table, samples_per_table_next;
  logic [8:0]  table_pos, table_pos_next;
  logic [15:0] sample_pos, sample_pos_next;
  logic [8:0]  tables_started, tables_started_next;
  logic [15:0] idle_count, idle_count_next;
  logic        receiving, receiving_next;

  logic        accept;
  logic        buf_full;
  out_item_t   res_next;
  logic [15:0] word;
  logic [15:0] idle_inc;
  logic [15:0] sample_inc;
  logic [8:0]  lim;
  logic [3:0]  sample_bp;

  assign item_stall = buf_full;
  assign accept     = item_valid && !item_stall;
  assign word       = {hi_byte, item.rx_byte};
  assign idle_inc   = (idle_count == 16'hFFFF) ? idle_count : idle_count + 16'd1;
  assign sample_inc = sample_pos + 16'd1;
  assign lim        = (table_limit < LimCap) ? table_limit : LimCap;
  assign sample_bp  = {2'b00, byte_position[1:0]};

  // one step of the upload protocol
  always_comb begin
    in_sample_phase_next   = in_sample_phase;
    byte_position_next     = byte_position;
    hi_byte_next           = hi_byte;
    key_word_next          = key_word;
    magic_mismatch_next    = magic_mismatch;
    samples_per_table_next = samples_per_table;
    table_pos_next         = table_pos;
    sample_pos_next        = sample_pos;
    tables_started_next    = tables_started;
    idle_count_next        = idle_count;
    receiving_next         = receiving;
    res_next               = '0;

    if (item.mode == MODE_TICK) begin
      // idle timeout ends the upload
      idle_count_next = idle_inc;
      if (receiving && idle_inc >= idle_ticks) begin
        in_sample_phase_next = 1'b0;
        receiving_next       = 1'b0;
        table_pos_next       = '0;
        sample_pos_next      = '0;
        byte_position_next   = '0;
        magic_mismatch_next  = 1'b0;
        res_next.reply_valid = 1'b1;
        res_next.reply_code  = REPLY_FIN;
        res_next.commit      = (tables_started != 9'd0);
      end
    end else if (!in_sample_phase) begin
      // header hunt
      idle_count_next = '0;
      if (!byte_position[0]) begin
        hi_byte_next       = item.rx_byte;
        byte_position_next = byte_position + 4'd1;
      end else if (!byte_position[3]) begin
        if (word != MAGIC_WORDS[byte_position[2:1]]) begin
          magic_mismatch_next = 1'b1;
        end
        byte_position_next = byte_position + 4'd1;
      end else begin
        res_next.reply_valid = 1'b1;
        table_pos_next       = '0;
        sample_pos_next      = '0;
        tables_started_next  = '0;
        byte_position_next   = '0;
        magic_mismatch_next  = 1'b0;
        if (magic_mismatch) begin
          res_next.reply_code = REPLY_ERR;
          in_sample_phase_next = 1'b0;
          receiving_next       = 1'b0;
        end else begin
          res_next.reply_code    = REPLY_ACK;
          samples_per_table_next = word;
          in_sample_phase_next   = 1'b1;
        end
      end
    end else begin
      // sample phase: key word then value word
      idle_count_next = '0;
      receiving_next  = 1'b1;
      if (!sample_bp[0]) begin
        hi_byte_next       = item.rx_byte;
        byte_position_next = sample_bp + 4'd1;
      end else if (!sample_bp[1]) begin
        key_word_next      = word;
        byte_position_next = 4'd2;
      end else begin
        byte_position_next = '0;
        if (key_word != value_hash(word)) begin
          // bad key drops the upload
          res_next.reply_valid = 1'b1;
          res_next.reply_code  = REPLY_ERR;
          in_sample_phase_next = 1'b0;
          receiving_next       = 1'b0;
          table_pos_next       = '0;
          sample_pos_next      = '0;
          magic_mismatch_next  = 1'b0;
          tables_started_next  = '0;
        end else if (table_pos < lim) begin
          if (sample_pos == 16'd0) begin
            tables_started_next = tables_started + 9'd1;
          end
          res_next.sample_write = 1'b1;
          res_next.write_table  = table_pos[7:0];
          res_next.write_index  = sample_pos;
          res_next.write_value  = word;
          sample_pos_next       = sample_inc;
          if (sample_inc == samples_per_table) begin
            // table complete
            sample_pos_next      = '0;
            table_pos_next       = table_pos + 9'd1;
            res_next.reply_valid = 1'b1;
            res_next.reply_code  = REPLY_ACK;
          end
        end
      end
    end

    res_next.tables_loaded = tables_started_next;
    res_next.table_length  = samples_per_table_next;
  end

  // state update on each item transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_sample_phase   <= 1'b0;
      byte_position     <= '0;
      hi_byte           <= '0;
      key_word          <= '0;
      magic_mismatch    <= 1'b0;
      samples_per_table <= '0;
      table_pos         <= '0;
      sample_pos        <= '0;
      tables_started    <= '0;
      idle_count        <= '0;
      receiving         <= 1'b0;
    end else if (accept) begin
      in_sample_phase   <= in_sample_phase_next;
      byte_position     <= byte_position_next;
      hi_byte           <= hi_byte_next;
      key_word          <= key_word_next;
      magic_mismatch    <= magic_mismatch_next;
      samples_per_table <= samples_per_table_next;
      table_pos         <= table_pos_next;
      sample_pos        <= sample_pos_next;
      tables_started    <= tables_started_next;
      idle_count        <= idle_count_next;
      receiving         <= receiving_next;
    end
  end

  // result buffer
  wur_out_buf u_out_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (accept),
    .push_data    (res_next),
    .full         (buf_full),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef SYNTH
  // a stalled input means the output register holds a result
  assert property (@(posedge clk) disable iff (rst) item_stall |-> result_valid)
    else $error("item stalled with empty result register");

  // byte position stays within the header
  assert property (@(posedge clk) disable iff (rst) byte_position <= HDR_LAST_POS)
    else $error("byte position out of range");

  // commit only comes with a finished reply
  assert property (@(posedge clk) disable iff (rst)
      accept && res_next.commit |-> res_next.reply_valid && res_next.reply_code == REPLY_FIN)
    else $error("commit without finished reply");

  // sample position stays inside the announced table length
  assert property (@(posedge clk) disable iff (rst)
      in_sample_phase && samples_per_table != 16'd0 |-> sample_pos < samples_per_table)
    else $error("sample position beyond table length");
`endif

endmodule

[sim/tb_wavetable_upload_receiver.sv]
// Testbench for wavetable_upload_receiver: drives headers, keyed samples and ticks,
// predicts each result in a scoreboard class and checks it field by field.
// Depends on wur_pkg and the wavetable_upload_receiver top level.
module tb_wavetable_upload_receiver;
  import wur_pkg::*;

  localparam int unsigned TABLE_CAP   = MAX_TABLES_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PRINT_CAP   = 40;

  // upload predictor and store of predicted step results
  class upload_scoreboard;
    logic [8:0]  tbl_limit;
    logic [15:0] idle_limit;
    bit          sampling;
    bit          rx_active;
    bit          bad_magic;
    logic [3:0]  bpos;
    logic [15:0] wbuf;
    logic [15:0] key;
    logic [15:0] tbl_len;
    logic [15:0] smp_idx;
    logic [15:0] idle_cnt;
    logic [8:0]  tbl_idx;
    logic [8:0]  started;
    out_item_t   step_outcomes[$];
    int unsigned results_seen;
    int unsigned errors;

    function new();
      tbl_limit  = TABLE_LIMIT_RESET;
      idle_limit = IDLE_TICKS_RESET;
      sampling   = 1'b0;
      rx_active  = 1'b0;
      bad_magic  = 1'b0;
      bpos       = '0;
      wbuf       = '0;
      key        = '0;
      tbl_len    = '0;
      smp_idx    = '0;
      idle_cnt   = '0;
      tbl_idx    = '0;
      started    = '0;
      results_seen = 0;
      errors     = 0;
    endfunction

    // key that a sample value must carry
    function logic [15:0] key_of(input logic [15:0] v);
      logic [15:0] k;
      k = ~v + {v[0], 15'd0};
      k = k ^ (k >> 12);
      k = k * 16'd5;
      k = k ^ (k >> 4);
      k = k * 16'd2057;
      return k;
    endfunction

    function void set_register(input logic idx, input logic [31:0] data);
      case (idx)
        REG_TABLE_LIMIT: tbl_limit = data[8:0];
        REG_IDLE_TICKS:  idle_limit = data[15:0];
        default: ;
      endcase
    endfunction

    // drop out of an upload back to the header hunt
    function void quit_upload();
      sampling  = 1'b0;
      rx_active = 1'b0;
      tbl_idx   = '0;
      smp_idx   = '0;
      bpos      = '0;
      bad_magic = 1'b0;
    endfunction

    // one accepted transfer: update state and queue the predicted result
    function void advance(input in_item_t it);
      out_item_t   o;
      logic [15:0] w;
      int unsigned lim;
      o = '0;
      if (it.mode == MODE_TICK) begin
        if (idle_cnt != 16'hFFFF) idle_cnt = idle_cnt + 16'd1;
        if (rx_active && idle_cnt >= idle_limit) begin
          quit_upload();
          o.reply_valid = 1'b1;
          o.reply_code  = REPLY_FIN;
          o.commit      = (started != '0);
        end
      end else if (!sampling) begin
        // header hunt: four magic words then the length word
        idle_cnt = '0;
        if (!bpos[0]) begin
          wbuf = {it.rx_byte, 8'h00};
          bpos = bpos + 4'd1;
        end else begin
          w = {wbuf[15:8], it.rx_byte};
          wbuf = w;
          if (!bpos[3]) begin
            if (w != MAGIC_WORDS[bpos[2:1]]) bad_magic = 1'b1;
            bpos = bpos + 4'd1;
          end else begin
            o.reply_valid = 1'b1;
            if (bad_magic) begin
              o.reply_code = REPLY_ERR;
              quit_upload();
              started = '0;
            end else begin
              o.reply_code = REPLY_ACK;
              tbl_len   = w;
              tbl_idx   = '0;
              smp_idx   = '0;
              started   = '0;
              sampling  = 1'b1;
              bpos      = '0;
              bad_magic = 1'b0;
            end
          end
        end
      end else begin
        // sample phase: key word then value word
        idle_cnt  = '0;
        rx_active = 1'b1;
        bpos      = bpos & 4'd3;
        if (!bpos[0]) begin
          wbuf = {it.rx_byte, 8'h00};
          bpos = bpos + 4'd1;
        end else if (bpos == 4'd1) begin
          key  = {wbuf[15:8], it.rx_byte};
          wbuf = key;
          bpos = 4'd2;
        end else begin
          w    = {wbuf[15:8], it.rx_byte};
          wbuf = w;
          bpos = '0;
          lim  = (tbl_limit < TABLE_CAP) ? tbl_limit : TABLE_CAP;
          if (key != key_of(w)) begin
            o.reply_valid = 1'b1;
            o.reply_code  = REPLY_ERR;
            quit_upload();
            started = '0;
          end else if (tbl_idx < lim) begin
            if (smp_idx == '0) started = started + 9'd1;
            o.sample_write = 1'b1;
            o.write_table  = tbl_idx[7:0];
            o.write_index  = smp_idx;
            o.write_value  = w;
            smp_idx = smp_idx + 16'd1;
            if (smp_idx == tbl_len) begin
              smp_idx = '0;
              tbl_idx = tbl_idx + 9'd1;
              o.reply_valid = 1'b1;
              o.reply_code  = REPLY_ACK;
            end
          end
        end
      end
      o.tables_loaded = started;
      o.table_length  = tbl_len;
      step_outcomes.push_back(o);
    endfunction

    function int unsigned pending();
      return step_outcomes.size();
    endfunction

    task flag(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      if (errors <= PRINT_CAP)
        $display("ERROR result %0d %s: got %h want %h", results_seen, what, got, want);
    endtask

    // compare one accepted result with the oldest prediction
    task match(input out_item_t got);
      out_item_t want;
      results_seen++;
      if (step_outcomes.size() == 0) begin
        flag("result with none pending", 32'(got), '0);
      end else begin
        want = step_outcomes.pop_front();
        if (got.sample_write !== want.sample_write)
          flag("sample_write", 32'(got.sample_write), 32'(want.sample_write));
        if (got.write_table !== want.write_table)
          flag("write_table", 32'(got.write_table), 32'(want.write_table));
        if (got.write_index !== want.write_index)
          flag("write_index", 32'(got.write_index), 32'(want.write_index));
        if (got.write_value !== want.write_value)
          flag("write_value", 32'(got.write_value), 32'(want.write_value));
        if (got.reply_valid !== want.reply_valid)
          flag("reply_valid", 32'(got.reply_valid), 32'(want.reply_valid));
        if (got.reply_code !== want.reply_code)
          flag("reply_code", 32'(got.reply_code), 32'(want.reply_code));
        if (got.commit !== want.commit)
          flag("commit", 32'(got.commit), 32'(want.commit));
        if (got.tables_loaded !== want.tables_loaded)
          flag("tables_loaded", 32'(got.tables_loaded), 32'(want.tables_loaded));
        if (got.table_length !== want.table_length)
          flag("table_length", 32'(got.table_length), 32'(want.table_length));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  in_item_t           item = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  out_item_t          result;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  int unsigned        cycle_count = 0;
  bit                 calm = 1'b0;

  upload_scoreboard sb = new();

  wavetable_upload_receiver #(
    .MAX_TABLES(TABLE_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) sb.match(result);
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver stalls
  initial begin
    int unsigned stall_len;
    while (rst) @(posedge clk);
    forever begin
      result_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      stall_len = pick_gap();
      if (stall_len > 0) begin
        result_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // one input transfer, with an optional gap ahead of it
  task automatic send_item(input logic md, input logic [7:0] b);
    in_item_t    it;
    int unsigned gap;
    it.mode    = md;
    it.rx_byte = b;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.advance(it);
  endtask

  task automatic send_word(input logic [15:0] w);
    send_item(MODE_BYTE, w[15:8]);
    send_item(MODE_BYTE, w[7:0]);
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(MODE_TICK, 8'($urandom_range(0, 255)));
  endtask

  // header with one magic bit flipped when corrupt is set
  task automatic send_header(input logic [15:0] len, input bit corrupt);
    int unsigned bad_word;
    logic [15:0] w;
    bad_word = corrupt ? $urandom_range(0, 3) : 4;
    for (int i = 0; i < 4; i++) begin
      w = MAGIC_WORDS[i];
      if (i == bad_word) w = w ^ (16'h0001 << $urandom_range(0, 15));
      send_word(w);
    end
    send_word(len);
  endtask

  task automatic send_sample(input logic [15:0] v, input bit bad_key);
    logic [15:0] k;
    k = sb.key_of(v);
    if (bad_key) k = k ^ (16'h0001 << $urandom_range(0, 15));
    send_word(k);
    send_word(v);
  endtask

  // stop sending until every predicted result has come back
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup cycle then access cycle
  task automatic write_reg(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, data);
  endtask

  function automatic logic [15:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(1, 4));
    if (r < 85) return 16'($urandom_range(5, 12));
    if (r < 93) return 16'd0;
    return 16'($urandom_range(13, 65535));
  endfunction

  // one random upload: mostly well formed, some wrong magic or plain noise
  task automatic run_upload(input int unsigned n_max);
    int unsigned kind;
    int unsigned n;
    kind = $urandom_range(0, 99);
    calm = ($urandom_range(0, 4) == 0);
    if (kind < 8) begin
      send_header(pick_length(), 1'b1);
    end else if (kind < 14) begin
      repeat ($urandom_range(1, 16))
        send_item(($urandom_range(0, 3) == 0) ? MODE_TICK : MODE_BYTE,
                  8'($urandom_range(0, 255)));
    end else begin
      send_header(pick_length(), 1'b0);
      if ($urandom_range(0, 9) == 0) settle();
      n = $urandom_range(0, n_max);
      for (int i = 0; i < n; i++) begin
        if (sb.idle_limit > 2 && $urandom_range(0, 19) == 0) send_ticks($urandom_range(1, 2));
        send_sample(16'($urandom_range(0, 65535)), $urandom_range(0, 24) == 0);
      end
      if ($urandom_range(0, 9) == 0) send_ticks($urandom_range(0, sb.idle_limit));
      else send_ticks(int'(sb.idle_limit) + 1);
    end
    calm = 1'b0;
  endtask

  task automatic run_phase(input logic [8:0] limit, input logic [15:0] idle,
                           input int unsigned uploads, input int unsigned n_max);
    settle();
    write_reg(REG_TABLE_LIMIT, 32'(limit));
    write_reg(REG_IDLE_TICKS, 32'(idle));
    repeat (uploads) run_upload(n_max);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle tick, good header, extreme values, bad key
    send_ticks(1);
    send_header(16'd1, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b1);
    send_ticks(1);

    // no tables allowed, finish on the first tick
    run_phase(9'd0, 16'd0, 5, 6);
    run_phase(9'd1, 16'd3, 5, 8);
    run_phase(9'd3, 16'd1, 5, 8);

    // two tables of one sample each, later samples dropped past the limit
    settle();
    write_reg(REG_TABLE_LIMIT, 32'd2);
    write_reg(REG_IDLE_TICKS, 32'd2);
    send_header(16'd1, 1'b0);
    repeat (4) send_sample(16'($urandom_range(0, 65535)), 1'b0);
    send_ticks(3);

    // longest idle timeout holds off the finish, a short one then ends it
    settle();
    write_reg(REG_IDLE_TICKS, 32'd65535);
    send_header(16'd2, 1'b0);
    repeat (2) send_sample(16'($urandom_range(0, 65535)), 1'b0);
    send_ticks(20);
    settle();
    write_reg(REG_IDLE_TICKS, 32'd1);
    send_ticks(1);

    repeat (2)
      run_phase(9'($urandom_range(0, 256)), 16'($urandom_range(0, 8)), 6, 10);
    run_phase(9'd256, 16'd12, 6, 10);

    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[wavetable_upload_receiver.f]
design/wur_pkg.sv
design/wur_out_buf.sv
design/wavetable_upload_receiver.sv
sim/tb_wavetable_upload_receiver.sv
